@@ rtl/olifr_pkg.sv @@
// ----------------------------------------------------------------------------
// olifr_pkg: shared constants for the ordered list unit
// Field widths, operation and status codes, default capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olifr_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 256;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned FILL_W   = 9;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

endpackage

@@ rtl/olifr_ram.sv @@
// ----------------------------------------------------------------------------
// olifr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olifr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ordered_list_insert_find_remove_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_list_insert_find_remove_unit: ordered list with linear search
// Sequence: an insert appends at slot count and passes through ST_FIN to the
//   output register; find and remove scan the slots in order from slot 0 up to
//   the first match (the whole list when absent); remove then moves the rest down.
// Throughput: one item at a time; the next item is accepted only once the last
//   result has entered the output register, so the scan up to the match and the
//   move-down of the rest through the single read port of the entry RAM, and any output stalls, hold the input.
// Reset: count and control clear at once; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_insert_find_remove_unit #(
  parameter int unsigned CAPACITY = olifr_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [olifr_pkg::KIND_W-1:0]        in_kind_i,
  input  logic signed [olifr_pkg::VALUE_W-1:0] in_value_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [olifr_pkg::STATUS_W-1:0]      out_status_o,
  output logic [olifr_pkg::POS_W-1:0]         out_position_o,
  output logic [olifr_pkg::FILL_W-1:0]        out_fill_count_o
);

  import olifr_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);      // entry address
  localparam int unsigned CW = $clog2(CAPACITY + 1);  // count, 0..CAPACITY
  // widths used to fit the internal position / count into the output fields
  localparam int unsigned PW = (AW > POS_W)  ? AW : POS_W;
  localparam int unsigned FW = (CW > FILL_W) ? CW : FILL_W;

  typedef enum logic [1:0] {
    ST_IDLE,   // ready for an item
    ST_SCAN,   // streaming reads, comparing each word when its registered read data returns
    ST_SHIFT,  // remove: read slot i+1, write the returned word to slot i
    ST_FIN     // result ready, waiting for the output register
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       idx_q, idx_d;          // next read address
  logic                pend_q, pend_d;        // a read is in flight
  logic [CW-1:0]       pend_idx_q, pend_idx_d;// address of that read
  logic                rm_q, rm_d;            // item is a remove
  logic [VALUE_W-1:0]  value_q, value_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [AW-1:0]       res_pos_q, res_pos_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [POS_W-1:0]    out_pos_q, out_pos_d;
  logic [FILL_W-1:0]   out_fill_q, out_fill_d;

  // RAM port signals
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VALUE_W-1:0]  ram_wdata;
  logic [VALUE_W-1:0]  ram_rdata;

  logic                accept;
  logic                full;
  logic                issue;
  logic                load_out;
  logic [CW-1:0]       shift_dst;             // slot below the word in flight
  logic [PW-1:0]       pos_ext;
  logic [FW-1:0]       fill_ext;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign full       = (count_q == CW'(CAPACITY));
  // in scan or shift, a read goes out whenever slots below count are left to visit
  assign issue      = ((state_q == ST_SCAN) || (state_q == ST_SHIFT)) && (idx_q != count_q);
  // the output register takes a new result when it is empty or being drained
  assign load_out   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign shift_dst  = pend_idx_q - 1'b1;

  assign pos_ext  = PW'(res_pos_q);
  assign fill_ext = FW'(count_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pend_d       = 1'b0;
    pend_idx_d   = idx_q;
    rm_d         = rm_q;
    value_d      = value_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[AW-1:0];
    ram_wdata    = $unsigned(in_value_i);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          value_d      = $unsigned(in_value_i);
          rm_d         = (in_kind_i == KIND_REMOVE);
          idx_d        = '0;
          res_pos_d    = '0;
          res_status_d = STATUS_NOT_FOUND;
          case (in_kind_i)
            KIND_INSERT: begin
              state_d = ST_FIN;
              if (full) begin
                res_status_d = STATUS_FULL;
              end else begin
                // append at slot count
                ram_we       = 1'b1;
                res_pos_d    = count_q[AW-1:0];
                res_status_d = STATUS_OK;
                count_d      = count_q + 1'b1;
              end
            end
            KIND_FIND, KIND_REMOVE: begin
              state_d = ST_SCAN;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        pend_d = issue;
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (pend_q && (ram_rdata == value_q)) begin
          // first match; in-flight read is dropped
          pend_d       = 1'b0;
          res_pos_d    = pend_idx_q[AW-1:0];
          res_status_d = STATUS_OK;
          if (rm_q) begin
            idx_d   = pend_idx_q + 1'b1;
            state_d = ST_SHIFT;
          end else begin
            state_d = ST_FIN;
          end
        end else if (!pend_q && !issue) begin
          // every slot below count compared, none equal
          state_d = ST_FIN;
        end
      end

      ST_SHIFT: begin
        pend_d = issue;
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (pend_q) begin
          // word read from slot i lands in slot i-1
          ram_we    = 1'b1;
          ram_waddr = shift_dst[AW-1:0];
          ram_wdata = ram_rdata;
        end else if (!issue) begin
          count_d = count_q - 1'b1;
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register, parts the result channel from the datapath
  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_fill_d   = out_fill_q;
    if (load_out) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_pos_d    = pos_ext[POS_W-1:0];
      out_fill_d   = fill_ext[FILL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    rm_q         <= rm_d;
    value_q      <= value_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_fill_q   <= out_fill_d;
  end

  olifr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_position_o   = out_pos_q;
  assign out_fill_count_o = out_fill_q;

endmodule

@@ rtl/olifr_checker.sv @@
// ----------------------------------------------------------------------------
// olifr_checker: port-level assertions for the ordered list unit
// Attached to the top level by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olifr_checker #(
  parameter int unsigned CAPACITY = olifr_pkg::DEFAULT_CAPACITY
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic [olifr_pkg::KIND_W-1:0]         in_kind_i,
  input logic signed [olifr_pkg::VALUE_W-1:0] in_value_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [olifr_pkg::STATUS_W-1:0]       out_status_o,
  input logic [olifr_pkg::POS_W-1:0]          out_position_o,
  input logic [olifr_pkg::FILL_W-1:0]         out_fill_count_o
);

  import olifr_pkg::*;

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(out_status_o) && $stable(out_position_o) && $stable(out_fill_count_o))
    else $error("result changed while stalled");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("new item taken before the previous one finished");

  // refused insert only when the list is full
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == STATUS_FULL) |-> out_fill_count_o == FILL_W'(CAPACITY))
    else $error("full status with list not full");

  // results without a position report slot zero
  a_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != STATUS_OK) |-> out_position_o == '0)
    else $error("position set on a failed operation");

endmodule

bind ordered_list_insert_find_remove_unit olifr_checker #(
  .CAPACITY (CAPACITY)
) u_olifr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .in_kind_i        (in_kind_i),
  .in_value_i       (in_value_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_status_o     (out_status_o),
  .out_position_o   (out_position_o),
  .out_fill_count_o (out_fill_count_o)
);

@@ bench/olifr_list_checker.sv @@
// ----------------------------------------------------------------------------
// olifr_list_checker: result checker for the ordered list unit
// Watches both channels, tracks a shadow copy of the list, and compares every
// result with the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olifr_list_checker #(
  parameter int unsigned CAPACITY = olifr_pkg::DEFAULT_CAPACITY
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [olifr_pkg::KIND_W-1:0]         in_kind_i,
  input  logic signed [olifr_pkg::VALUE_W-1:0] in_value_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic [olifr_pkg::STATUS_W-1:0]       out_status_i,
  input  logic [olifr_pkg::POS_W-1:0]          out_position_i,
  input  logic [olifr_pkg::FILL_W-1:0]         out_fill_count_i,
  output int                                   mismatch_count_o,
  output int                                   pending_o,
  output int                                   results_seen_o,
  output int                                   refused_inserts_o,
  output int                                   hits_o,
  output int                                   peak_fill_o
);

  import olifr_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [FILL_W-1:0]   fill;
  } list_result_t;

  logic [VALUE_W-1:0] shadow_slots [CAPACITY];
  int                 shadow_count;
  list_result_t       awaited_results [$];

  int mismatch_count;
  int pending;
  int results_seen;
  int refused_inserts;
  int hits;
  int peak_fill;

  assign mismatch_count_o  = mismatch_count;
  assign pending_o         = pending;
  assign results_seen_o    = results_seen;
  assign refused_inserts_o = refused_inserts;
  assign hits_o            = hits;
  assign peak_fill_o       = peak_fill;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Applies one operation to the shadow list and returns what the unit must say.
  function automatic list_result_t apply_list_op(input logic [KIND_W-1:0] kind,
                                                 input logic [VALUE_W-1:0] value);
    list_result_t r;
    int           hit;
    r.status   = STATUS_NOT_FOUND;
    r.position = '0;
    hit        = -1;
    case (kind)
      KIND_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = STATUS_FULL;
          refused_inserts++;
        end else begin
          shadow_slots[shadow_count] = value;
          r.position = shadow_count[POS_W-1:0];
          r.status   = STATUS_OK;
          shadow_count++;
        end
      end
      KIND_FIND, KIND_REMOVE: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_slots[i] == value) hit = i;
        end
        if (hit >= 0) begin
          r.status   = STATUS_OK;
          r.position = hit[POS_W-1:0];
          hits++;
          if (kind == KIND_REMOVE) begin
            for (int i = hit; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i + 1];
            shadow_count--;
          end
        end
      end
      default: ;  // unused code: no change, reported as not found
    endcase
    r.fill = shadow_count[FILL_W-1:0];
    if (shadow_count > peak_fill) peak_fill = shadow_count;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      awaited_results.delete();
      shadow_count    = 0;
      mismatch_count  = 0;
      pending         = 0;
      results_seen    = 0;
      refused_inserts = 0;
      hits            = 0;
      peak_fill       = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(apply_list_op(in_kind_i, in_value_i));
      end
      if (out_valid_i && !out_stall_i) begin
        results_seen++;
        got.status   = out_status_i;
        got.position = out_position_i;
        got.fill     = out_fill_count_i;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d position %0d fill %0d",
                                    got.status, got.position, got.fill));
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status exp %0d got %0d", want.status, got.status));
          if (got.position !== want.position)
            report_mismatch($sformatf("position exp %0d got %0d",
                                      want.position, got.position));
          if (got.fill !== want.fill)
            report_mismatch($sformatf("fill_count exp %0d got %0d", want.fill, got.fill));
        end
      end
      pending = awaited_results.size();
    end
  end

endmodule

@@ bench/tb_ordered_list_insert_find_remove_unit.sv @@
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_find_remove_unit: testbench for the ordered list unit
// Directed corner items, then random segments that fill the list to capacity,
// search it and drain it, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ordered_list_insert_find_remove_unit;

  import olifr_pkg::*;

  localparam int unsigned CAPACITY     = DEFAULT_CAPACITY;
  // The only code the package leaves unnamed; the unit must treat it as a no-op.
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
  // Idle cycles with no handshake on either side before the run is abandoned.
  // Slowest item: scan to the match plus move-down, plus the longest stall and
  // gap below; taken several times over.
  localparam int unsigned IDLE_LIMIT   = 4000;
  // Quiet time after the last result, enough to catch a stray extra result.
  localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 100;

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_stall_o;
  logic [KIND_W-1:0]         in_kind_i      = KIND_INSERT;
  logic signed [VALUE_W-1:0] in_value_i     = '0;
  logic                      out_valid_o;
  logic                      out_stall_i    = 1'b0;
  logic [STATUS_W-1:0]       out_status_o;
  logic [POS_W-1:0]          out_position_o;
  logic [FILL_W-1:0]         out_fill_count_o;

  int mismatches;
  int pending_results;
  int results_seen;
  int refused_inserts;
  int hits;
  int peak_fill;

  // Pacing knobs, changed per segment so that some stretches run with no idling.
  bit          quiet_tx = 1'b0;
  bit          quiet_rx = 1'b0;
  int unsigned stall_left = 0;
  int unsigned stall_roll;
  int unsigned idle_cycles = 0;

  // Small pool of values so that finds and removes hit often and duplicates
  // exist; the extremes sit in the first four slots.
  logic [VALUE_W-1:0] value_pool [16];

  always #5 clk_i = ~clk_i;

  ordered_list_insert_find_remove_unit #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_kind_i       (in_kind_i),
    .in_value_i      (in_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_status_o    (out_status_o),
    .out_position_o  (out_position_o),
    .out_fill_count_o(out_fill_count_o)
  );

  olifr_list_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_kind_i        (in_kind_i),
    .in_value_i       (in_value_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_status_i     (out_status_o),
    .out_position_i   (out_position_o),
    .out_fill_count_i (out_fill_count_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending_results),
    .results_seen_o   (results_seen),
    .refused_inserts_o(refused_inserts),
    .hits_o           (hits),
    .peak_fill_o      (peak_fill)
  );

  // Result side back-pressure: mostly open, short bursts, and now and then a
  // long hold. One nonblocking write of out_stall_i per edge.
  always @(posedge clk_i) begin
    stall_roll = $urandom_range(99);
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (quiet_rx || stall_roll < 75) begin
      out_stall_i <= 1'b0;
    end else if (stall_roll < 96) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(2);
    end else begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(50, 15);
    end
  end

  // Watchdog: any handshake on either channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_results);
      $display("tb_ordered_list_insert_find_remove_unit failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sender gap: mostly back to back, some short pauses, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (quiet_tx || roll < 70) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Drives one item and returns at the edge that accepts it. valid is left
  // high so a back-to-back item only rewrites the payload.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_kind_i  <= kind;
    in_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // One random segment. Percentages pick the operation (what is left over goes
  // to the reserved code); pool_pct is the share of values drawn from the pool.
  task automatic run_segment(input int n, input int ins_pct, input int find_pct,
                             input int rem_pct, input int pool_pct);
    int unsigned        roll;
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    quiet_tx = ($urandom_range(3) == 0);
    quiet_rx = ($urandom_range(3) == 0);
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < ins_pct) kind = KIND_INSERT;
      else if (roll < ins_pct + find_pct) kind = KIND_FIND;
      else if (roll < ins_pct + find_pct + rem_pct) kind = KIND_REMOVE;
      else kind = KIND_RESERVED;
      if ($urandom_range(99) < pool_pct) value = value_pool[$urandom_range(15)];
      else value = $urandom;
      send_item(kind, value);
    end
  endtask

  initial begin
    value_pool[0] = 32'h7fff_ffff;
    value_pool[1] = 32'h8000_0000;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 16; i++) value_pool[i] = $urandom;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: searches on an empty list, reserved code, extremes, duplicates,
    // first-match rule, removal at head, middle and tail, back to empty.
    send_item(KIND_FIND,     32'h0000_0000);
    send_item(KIND_REMOVE,   32'h0000_0005);
    send_item(KIND_RESERVED, 32'h0000_0000);
    send_item(KIND_INSERT,   32'h7fff_ffff);
    send_item(KIND_INSERT,   32'h8000_0000);
    send_item(KIND_INSERT,   32'h0000_0000);
    send_item(KIND_INSERT,   32'hffff_ffff);
    send_item(KIND_INSERT,   32'h7fff_ffff);   // duplicate of slot 0
    send_item(KIND_FIND,     32'h7fff_ffff);   // first match wins
    send_item(KIND_FIND,     32'hffff_ffff);
    send_item(KIND_FIND,     32'h7fff_fffe);   // near miss
    send_item(KIND_RESERVED, 32'h0000_0000);   // present, still not found
    send_item(KIND_REMOVE,   32'h7fff_ffff);   // head, list moves down
    send_item(KIND_FIND,     32'h7fff_ffff);   // duplicate now at the tail
    send_item(KIND_REMOVE,   32'h7fff_ffff);   // tail
    send_item(KIND_REMOVE,   32'h0000_0000);   // middle
    send_item(KIND_REMOVE,   32'h8000_0000);
    send_item(KIND_REMOVE,   32'hffff_ffff);   // list empty again
    send_item(KIND_REMOVE,   32'hffff_ffff);
    send_item(KIND_INSERT,   32'h5555_5555);
    send_item(KIND_INSERT,   32'haaaa_aaaa);

    // Random: mixed traffic, then fill to capacity and work a full list,
    // drain it, run on mostly unrelated values, and finish mixed.
    run_segment(150, 40, 30, 25, 75);
    run_segment(270, 100, 0, 0, 70);
    run_segment(60, 40, 40, 15, 75);
    run_segment(300, 5, 15, 78, 90);
    run_segment(200, 45, 30, 20, 20);
    run_segment(170, 35, 30, 30, 75);
    in_valid_i <= 1'b0;

    while (pending_results != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d results: %0d hits on find or remove, %0d inserts refused",
             results_seen, hits, refused_inserts);
    $display("list filled up to %0d of %0d entries", peak_fill, CAPACITY);
    if (mismatches == 0 && pending_results == 0) begin
      $display("tb_ordered_list_insert_find_remove_unit passed");
    end else begin
      $display("tb_ordered_list_insert_find_remove_unit failed");
    end
    $finish;
  end

endmodule
